// File: rtl/ppm_p6_stream_decoder_core_defines.svh
// assertion macros for the ppm p6 stream decoder
`ifndef PPM_P6_STREAM_DECODER_CORE_DEFINES_SVH
`define PPM_P6_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppm decoder: same-cycle check failed");
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppm decoder: next-cycle check failed");
`else
`define PPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/ppm_p6_pkg.sv
package ppm_p6_pkg;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC   = 2'd0;
    localparam logic [1:0] ERR_MAXVAL  = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG = 2'd2;

    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_COMMENT = 3'd1;
    localparam logic [2:0] PH_PIXELS  = 3'd2;
    localparam logic [2:0] PH_DONE    = 3'd3;
    localparam logic [2:0] PH_ERROR   = 3'd4;

    localparam logic [1:0] FLD_MAGIC  = 2'd0;
    localparam logic [1:0] FLD_WIDTH  = 2'd1;
    localparam logic [1:0] FLD_HEIGHT = 2'd2;
    localparam logic [1:0] FLD_MAXVAL = 2'd3;

    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_6       = 8'h36;
    localparam logic [7:0] CH_2       = 8'h32;
    localparam logic [7:0] CH_5       = 8'h35;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] pixel_word;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  error_code;
        logic        last;
    } result_t;

endpackage

// File: rtl/ppm_p6_stream_decoder_core.sv
// ppm p6 stream decoder
// input channel: data_valid / data_stall carry one file byte per item in
// data_byte; frame_start high on an item restarts the parser before that
// byte is handled. result channel: result_valid / result_stall carry at most
// one result per input item: header complete (with width and height), a
// packed pixel word R<<24|G<<16|B<<8, or an error code.
// each result is registered in the result register, or in the skid register
// while the receiver stalls. throughput: one byte per cycle while data_stall
// is low; the header and pixel logic is a single short update of the parser
// state. the width * height product is taken from a register fed by the width
// and height registers, so the pixel count is ready when the max value ends.
// when the receiver stalls, the result register holds and one more result
// goes into a skid register; data_stall rises only while that skid register
// is full, so a result-side stall reaches the input once a second result waits
// after an error, or after the last pixel, bytes are taken and dropped until
// frame_start. reset clears the parser to the start of a header and empties
// both result registers.
`include "ppm_p6_stream_decoder_core_defines.svh"

module ppm_p6_stream_decoder_core #(
    parameter int DIM_BITS  = 16,
    parameter int MAX_TOKEN = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        frame_start,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [31:0] pixel_word,
    output logic [15:0] image_width,
    output logic [15:0] image_height,
    output logic [1:0]  error_code,
    output logic        last
);
    import ppm_p6_pkg::*;

    localparam int LEN_BITS = $clog2(MAX_TOKEN + 1);
    localparam int NUM_BITS = DIM_BITS + 4;

    logic [2:0]            phase_reg, phase_next;
    logic [1:0]            field_reg, field_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [DIM_BITS-1:0]   num_reg, num_next;
    logic                  ended_reg, ended_next;
    logic                  p6_reg, p6_next;
    logic                  m255_reg, m255_next;
    logic [DIM_BITS-1:0]   width_reg, width_next;
    logic [DIM_BITS-1:0]   height_reg, height_next;
    logic [31:0]           left_reg, left_next;
    logic [1:0]            bip_reg, bip_next;
    logic [7:0]            red_reg, red_next;
    logic [7:0]            green_reg, green_next;
    logic [2*DIM_BITS-1:0] product_reg;

    logic [2:0]            cur_phase;
    logic [1:0]            cur_field;
    logic [LEN_BITS-1:0]   cur_len;
    logic [DIM_BITS-1:0]   cur_num;
    logic                  cur_ended;
    logic                  cur_p6;
    logic                  cur_m255;
    logic [DIM_BITS-1:0]   cur_width;
    logic [DIM_BITS-1:0]   cur_height;
    logic [31:0]           cur_left;
    logic [1:0]            cur_bip;

    logic                  data_fire;
    logic                  is_white;
    logic                  is_digit;
    logic                  magic_hit;
    logic                  maxval_hit;
    logic [NUM_BITS-1:0]   num_times10;
    logic [63:0]           prod_ext;
    logic [31:0]           pixel_count;
    logic [31:0]           width_ext;
    logic [31:0]           height_ext;
    logic [31:0]           left_dec;

    logic                  new_valid;
    result_t               new_res;
    logic                  out_free;
    logic                  result_valid_reg;
    logic                  skid_valid_reg;
    result_t               out_reg;
    result_t               skid_reg;

    assign data_fire = data_valid && !data_stall;

    // frame_start restarts the parser before the byte is used
    assign cur_phase  = frame_start ? PH_HEADER : phase_reg;
    assign cur_field  = frame_start ? FLD_MAGIC : field_reg;
    assign cur_len    = frame_start ? '0 : len_reg;
    assign cur_num    = frame_start ? '0 : num_reg;
    assign cur_ended  = frame_start ? 1'b0 : ended_reg;
    assign cur_p6     = frame_start ? 1'b1 : p6_reg;
    assign cur_m255   = frame_start ? 1'b1 : m255_reg;
    assign cur_width  = frame_start ? '0 : width_reg;
    assign cur_height = frame_start ? '0 : height_reg;
    assign cur_left   = frame_start ? '0 : left_reg;
    assign cur_bip    = frame_start ? 2'd0 : bip_reg;

    assign is_white = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
    assign is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
    assign magic_hit = (cur_len == LEN_BITS'(0) && data_byte == CH_P)
                    || (cur_len == LEN_BITS'(1) && data_byte == CH_6);
    assign maxval_hit = (cur_len == LEN_BITS'(0) && data_byte == CH_2)
                     || (cur_len == LEN_BITS'(1) && data_byte == CH_5)
                     || (cur_len == LEN_BITS'(2) && data_byte == CH_5);
    assign num_times10 = (NUM_BITS'(cur_num) << 3) + (NUM_BITS'(cur_num) << 1)
                       + NUM_BITS'(data_byte - CH_0);

    assign prod_ext    = 64'(product_reg);
    assign pixel_count = (|prod_ext[63:32]) ? 32'hFFFF_FFFF : prod_ext[31:0];
    assign width_ext   = 32'(cur_width);
    assign height_ext  = 32'(cur_height);
    assign left_dec    = cur_left - 32'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        field_next  = field_reg;
        len_next    = len_reg;
        num_next    = num_reg;
        ended_next  = ended_reg;
        p6_next     = p6_reg;
        m255_next   = m255_reg;
        width_next  = width_reg;
        height_next = height_reg;
        left_next   = left_reg;
        bip_next    = bip_reg;
        red_next    = red_reg;
        green_next  = green_reg;
        new_valid   = 1'b0;
        new_res.kind         = KIND_HEADER;
        new_res.pixel_word   = '0;
        new_res.image_width  = width_ext[15:0];
        new_res.image_height = height_ext[15:0];
        new_res.error_code   = ERR_MAGIC;
        new_res.last         = 1'b0;

        if (data_fire)
        begin
            phase_next  = cur_phase;
            field_next  = cur_field;
            len_next    = cur_len;
            num_next    = cur_num;
            ended_next  = cur_ended;
            p6_next     = cur_p6;
            m255_next   = cur_m255;
            width_next  = cur_width;
            height_next = cur_height;
            left_next   = cur_left;
            bip_next    = cur_bip;
            if (frame_start)
            begin
                red_next   = '0;
                green_next = '0;
            end

            unique case (cur_phase)
                PH_HEADER:
                begin
                    if (data_byte == CH_HASH)
                    begin
                        phase_next = PH_COMMENT;
                    end
                    else if (is_white)
                    begin
                        // token ends
                        len_next   = '0;
                        num_next   = '0;
                        ended_next = 1'b0;
                        p6_next    = 1'b1;
                        m255_next  = 1'b1;
                        unique case (cur_field)
                            FLD_MAGIC:
                            begin
                                if (!(cur_p6 && cur_len == LEN_BITS'(2)))
                                begin
                                    phase_next         = PH_ERROR;
                                    new_valid          = 1'b1;
                                    new_res.kind       = KIND_ERROR;
                                    new_res.error_code = ERR_MAGIC;
                                end
                                else
                                begin
                                    field_next = FLD_WIDTH;
                                end
                            end
                            FLD_WIDTH:
                            begin
                                width_next = cur_num;
                                field_next = FLD_HEIGHT;
                            end
                            FLD_HEIGHT:
                            begin
                                height_next = cur_num;
                                field_next  = FLD_MAXVAL;
                            end
                            default:
                            begin
                                new_valid = 1'b1;
                                if (!(cur_m255 && cur_len == LEN_BITS'(3)))
                                begin
                                    phase_next         = PH_ERROR;
                                    new_res.kind       = KIND_ERROR;
                                    new_res.error_code = ERR_MAXVAL;
                                end
                                else
                                begin
                                    left_next    = pixel_count;
                                    bip_next     = 2'd0;
                                    phase_next   = (pixel_count == 32'd0) ? PH_DONE : PH_PIXELS;
                                    new_res.kind = KIND_HEADER;
                                    new_res.last = (pixel_count == 32'd0);
                                end
                            end
                        endcase
                    end
                    else if (cur_len >= LEN_BITS'(MAX_TOKEN))
                    begin
                        phase_next         = PH_ERROR;
                        new_valid          = 1'b1;
                        new_res.kind       = KIND_ERROR;
                        new_res.error_code = ERR_TOO_LONG;
                    end
                    else
                    begin
                        if (!magic_hit)
                        begin
                            p6_next = 1'b0;
                        end
                        if (!maxval_hit)
                        begin
                            m255_next = 1'b0;
                        end
                        if (!cur_ended && is_digit)
                        begin
                            num_next = (|num_times10[NUM_BITS-1:DIM_BITS])
                                     ? '1 : num_times10[DIM_BITS-1:0];
                        end
                        else
                        begin
                            ended_next = 1'b1;
                        end
                        len_next = cur_len + LEN_BITS'(1);
                    end
                end
                PH_COMMENT:
                begin
                    if (data_byte == CH_NL)
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_PIXELS:
                begin
                    unique case (cur_bip)
                        2'd0:
                        begin
                            red_next = data_byte;
                            bip_next = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next = data_byte;
                            bip_next   = 2'd2;
                        end
                        default:
                        begin
                            bip_next           = 2'd0;
                            left_next          = left_dec;
                            phase_next         = (left_dec == 32'd0) ? PH_DONE : PH_PIXELS;
                            new_valid          = 1'b1;
                            new_res.kind       = KIND_PIXEL;
                            new_res.pixel_word = {red_reg, green_reg, data_byte, 8'h00};
                            new_res.last       = (left_dec == 32'd0);
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            field_reg  <= FLD_MAGIC;
            len_reg    <= '0;
            num_reg    <= '0;
            ended_reg  <= 1'b0;
            p6_reg     <= 1'b1;
            m255_reg   <= 1'b1;
            width_reg  <= '0;
            height_reg <= '0;
            left_reg   <= '0;
            bip_reg    <= 2'd0;
            red_reg    <= '0;
            green_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            field_reg  <= field_next;
            len_reg    <= len_next;
            num_reg    <= num_next;
            ended_reg  <= ended_next;
            p6_reg     <= p6_next;
            m255_reg   <= m255_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            left_reg   <= left_next;
            bip_reg    <= bip_next;
            red_reg    <= red_next;
            green_reg  <= green_next;
        end
    end

    // pixel count, ready well before the max value token ends
    always_ff @(posedge clk)
    begin
        product_reg <= (2*DIM_BITS)'(width_reg) * (2*DIM_BITS)'(height_reg);
    end

    // result register and skid register
    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= skid_valid_reg || new_valid;
            skid_valid_reg   <= 1'b0;
        end
        else if (new_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : new_res;
        end
        else if (new_valid)
        begin
            skid_reg <= new_res;
        end
    end

    assign data_stall   = skid_valid_reg;
    assign result_valid = result_valid_reg;
    assign kind         = out_reg.kind;
    assign pixel_word   = out_reg.pixel_word;
    assign image_width  = out_reg.image_width;
    assign image_height = out_reg.image_height;
    assign error_code   = out_reg.error_code;
    assign last         = out_reg.last;

    `PPM_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, result_valid_reg)
    `PPM_ASSERT_IMP(a_pixels_pending, clk, rst_n, phase_reg == PH_PIXELS, left_reg != 32'd0)
    `PPM_ASSERT_IMP(a_bip_range, clk, rst_n, 1'b1, bip_reg != 2'd3)
    `PPM_ASSERT_NEXT(a_error_holds, clk, rst_n,
        phase_reg == PH_ERROR && !(data_fire && frame_start), phase_reg == PH_ERROR)

endmodule
